/* src/biquad_df2_multichannel_filter_macros.svh */
// Assertion macros for the biquad filter block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BIQUAD_DF2_MULTICHANNEL_FILTER_MACROS_SVH
`define BIQUAD_DF2_MULTICHANNEL_FILTER_MACROS_SVH

// ante true now -> cons true now
`define BQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true now -> cons true in the next cycle
`define BQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bq_pkg.sv */
// Shared constants, types and codes for the biquad filter block.
// No dependencies.
package bq_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W   = 24;
    localparam int CHAN_W     = 3;
    localparam int COEF_W     = 24;
    localparam int DELAY_W    = 32;
    localparam int PROD_W     = COEF_W + DELAY_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 18;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;
    localparam int STORE_W    = 2 * DELAY_W;

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd262144;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_A1W1 = 3'd1,
        MUL_A2W2 = 3'd2,
        MUL_B1W1 = 3'd3,
        MUL_B2W2 = 3'd4,
        MUL_B0W  = 3'd5
    } bq_mul_t;

    typedef struct packed {
        logic    take;     // input beat accepted, start state read
        logic    load;     // capture delay words, seed w accumulator
        bq_mul_t mul_sel;  // operands for the product register
        logic    acw_sub;  // w accumulator minus product
        logic    wsat;     // round and saturate w
        logic    acy_init; // y accumulator from product
        logic    acy_add;  // y accumulator plus product
        logic    write;    // store {w, w1} for the channel
        logic    out_load; // round, saturate y into output register
    } bq_cmd_t;

    typedef struct packed {
        logic out_busy;
    } bq_status_t;

endpackage

/* src/bq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/bq_ctrl.sv */
// Sequencer for the biquad filter: steps one sample through the shared MAC.
// Depends on bq_pkg.
module bq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bq_pkg::bq_status_t status,
    output bq_pkg::bq_cmd_t    cmd
);
    import bq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_P1   = 9'b000000100,
        S_P2   = 9'b000001000,
        S_P3   = 9'b000010000,
        S_P4   = 9'b000100000,
        S_P5   = 9'b001000000,
        S_P6   = 9'b010000000,
        S_OUT  = 9'b100000000
    } bq_state_t;

    bq_state_t state_reg;
    bq_state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd.mul_sel = MUL_A1W1;
                state_next  = S_P2;
            end
            S_P2:
            begin
                cmd.acw_sub = 1'b1;
                cmd.mul_sel = MUL_A2W2;
                state_next  = S_P3;
            end
            S_P3:
            begin
                cmd.acw_sub = 1'b1;
                cmd.mul_sel = MUL_B1W1;
                state_next  = S_P4;
            end
            S_P4:
            begin
                cmd.wsat     = 1'b1;
                cmd.acy_init = 1'b1;
                cmd.mul_sel  = MUL_B2W2;
                state_next   = S_P5;
            end
            S_P5:
            begin
                cmd.acy_add = 1'b1;
                cmd.mul_sel = MUL_B0W;
                cmd.write   = 1'b1;
                state_next  = S_P6;
            end
            S_P6:
            begin
                cmd.acy_add = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/bq_dp.sv */
// Datapath for the biquad filter: coefficients, delay store, one multiplier,
// two accumulators and the output register. Depends on bq_pkg and bq_ram.
module bq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bq_pkg::bq_cmd_t                     cmd,
    output bq_pkg::bq_status_t                  status,
    input  logic                                cfg_valid,
    input  logic [bq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [bq_pkg::COEF_W-1:0]    cfg_data,
    input  logic signed [bq_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [bq_pkg::CHAN_W-1:0]           chan_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bq_pkg::SAMPLE_W-1:0]  sample_out,
    output logic [bq_pkg::CHAN_W-1:0]           chan_out
);
    import bq_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);

    function automatic logic signed [RND_W-1:0] bq_round(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = a + RND_HALF;
        return RND_W'(s >>> FRAC_SHIFT);
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat_w(input logic signed [RND_W-1:0] r);
        logic ovf;
        ovf = (r[RND_W-1:DELAY_W-1] != '0) && (r[RND_W-1:DELAY_W-1] != '1);
        return ovf ? {r[RND_W-1], {(DELAY_W-1){~r[RND_W-1]}}} : r[DELAY_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_y(input logic signed [RND_W-1:0] r);
        logic ovf;
        ovf = (r[RND_W-1:SAMPLE_W-1] != '0) && (r[RND_W-1:SAMPLE_W-1] != '1);
        return ovf ? {r[RND_W-1], {(SAMPLE_W-1){~r[RND_W-1]}}} : r[SAMPLE_W-1:0];
    endfunction

    logic signed [COEF_W-1:0]  b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CHAN_W-1:0]          ch_reg;
    logic [CH_AW-1:0]           addr_reg;
    logic                       ok_reg;
    logic [CHANNELS-1:0]        vld_reg;
    logic signed [DELAY_W-1:0]  w1_reg, w2_reg, w_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    accw_reg, accy_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [CHAN_W-1:0]          chan_out_reg;
    logic [STORE_W-1:0]         rd_data;
    logic                       hit;
    logic signed [COEF_W-1:0]   mul_c;
    logic signed [DELAY_W-1:0]  mul_v;

    bq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.write && ok_reg),
        .wr_addr (addr_reg),
        .wr_data ({w_reg, w1_reg}),
        .rd_en   (cmd.take),
        .rd_addr (CH_AW'(chan_index)),
        .rd_data (rd_data)
    );

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= B0_RESET;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_B0:  b0_reg <= cfg_data;
                REG_B1:  b1_reg <= cfg_data;
                REG_B2:  b2_reg <= cfg_data;
                REG_A1:  a1_reg <= cfg_data;
                REG_A2:  a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // channel entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.write && ok_reg)
        begin
            vld_reg[addr_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_A1W1:
            begin
                mul_c = a1_reg;
                mul_v = w1_reg;
            end
            MUL_A2W2:
            begin
                mul_c = a2_reg;
                mul_v = w2_reg;
            end
            MUL_B1W1:
            begin
                mul_c = b1_reg;
                mul_v = w1_reg;
            end
            MUL_B2W2:
            begin
                mul_c = b2_reg;
                mul_v = w2_reg;
            end
            MUL_B0W:
            begin
                mul_c = b0_reg;
                mul_v = w_reg;
            end
            default:
            begin
                mul_c = '0;
                mul_v = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_c) * PROD_W'(mul_v);
    assign hit       = ok_reg && vld_reg[addr_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg    <= sample_in;
            ch_reg   <= chan_index;
            addr_reg <= CH_AW'(chan_index);
            ok_reg   <= (int'(chan_index) < CHANNELS);
        end
        if (cmd.load)
        begin
            w1_reg   <= hit ? rd_data[STORE_W-1:DELAY_W] : '0;
            w2_reg   <= hit ? rd_data[DELAY_W-1:0] : '0;
            accw_reg <= ACC_W'(x_reg) <<< FRAC_SHIFT;
        end
        else if (cmd.acw_sub)
        begin
            accw_reg <= accw_reg - ACC_W'(prod_reg);
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.wsat)
        begin
            w_reg <= sat_w(bq_round(accw_reg));
        end
        if (cmd.acy_init)
        begin
            accy_reg <= ACC_W'(prod_reg);
        end
        else if (cmd.acy_add)
        begin
            accy_reg <= accy_reg + ACC_W'(prod_reg);
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= sat_y(bq_round(accy_reg));
            chan_out_reg   <= ch_reg;
        end
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign chan_out        = chan_out_reg;

endmodule

/* src/biquad_df2_multichannel_filter.sv */
// Multichannel direct form II biquad section, top level.
// Depends on bq_pkg, bq_ctrl, bq_dp (bq_ram) and the assertion macro header.
//
// Input channel: in_valid/in_ready with sample_in (Q1.23) and chan_index.
// Output channel: out_valid/out_ready with sample_out (Q1.23, saturated) and
// chan_out, one beat per input beat, in order.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; indexes
// 0..4 load b0, b1, b2, a1, a2 (Q6.18), others are dropped. Always ready.
// Each sample runs through one shared 24x32 multiplier: five products, each
// registered, with two accumulators; the per-channel delay words live in a
// RAM read once and written once per sample.
// Sequence: each sample steps through the load, product and output states of
// the multiplier sequence before the next input beat can be taken.
// Reset: coefficients return to b0 = 1.0 and the rest zero; every channel's
// delay words read as zero until first written, so no clearing pass is run.
// Stall: the finished result waits in the output register; a new input beat
// is taken once the previous result has moved into that register.
// Channels at or beyond the channel count run with zero state and keep none.
`include "biquad_df2_multichannel_filter_macros.svh"

module biquad_df2_multichannel_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bq_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [bq_pkg::CHAN_W-1:0]           chan_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bq_pkg::SAMPLE_W-1:0]  sample_out,
    output logic [bq_pkg::CHAN_W-1:0]           chan_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [bq_pkg::COEF_W-1:0]    cfg_data
);
    import bq_pkg::*;

    bq_cmd_t    cmd;
    bq_status_t status;

    assign cfg_ready = 1'b1;

    bq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .chan_index (chan_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .chan_out   (chan_out)
    );

    `BQ_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready held after beat")
    `BQ_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_valid && !out_ready), "result overwritten")
    `BQ_ASSERT_NEXT(a_out_after_load, cmd.out_load, out_valid, "loaded result not shown")

endmodule

/* tb/biquad_df2_multichannel_filter_tb.sv */
// Testbench for biquad_df2_multichannel_filter: checks filtered samples and channel echo
// against an in-bench fixed-point DF-II predictor with per-channel delay state.
// Depends on bq_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 100ps

module biquad_df2_multichannel_filter_tb;
    import bq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 245;
    localparam int TAIL_CYCLES    = 20;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]   C_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          chan;
    } filtered_beat_t;

    class biquad_scoreboard;
        longint coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
        longint delay_one [CHANNELS];
        longint delay_two [CHANNELS];
        filtered_beat_t expected_q [$];
        int errors;

        function new();
            coef_b0 = longint'(B0_RESET);
            coef_b1 = 0;
            coef_b2 = 0;
            coef_a1 = 0;
            coef_a2 = 0;
            foreach (delay_one[i])
            begin
                delay_one[i] = 0;
                delay_two[i] = 0;
            end
            errors = 0;
        endfunction

        function void load_coef(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] data);
            case (idx)
                REG_B0: coef_b0 = data;
                REG_B1: coef_b1 = data;
                REG_B2: coef_b2 = data;
                REG_A1: coef_a1 = data;
                REG_A2: coef_a2 = data;
                default: ;
            endcase
        endfunction

        // Q.41 -> Q.23, round half up, then clamp to a signed field of the given width
        function longint round_sat(longint acc, int bits);
            longint v, hi, lo;
            v  = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x, logic [CHAN_W-1:0] ch);
            longint w1, w2, w, y;
            bit kept;
            filtered_beat_t res;
            kept = int'(ch) < CHANNELS;
            w1 = 0;
            w2 = 0;
            if (kept)
            begin
                w1 = delay_one[ch];
                w2 = delay_two[ch];
            end
            w = round_sat((longint'(x) <<< FRAC_SHIFT) - coef_a1 * w1 - coef_a2 * w2, DELAY_W);
            y = round_sat(coef_b0 * w + coef_b1 * w1 + coef_b2 * w2, SAMPLE_W);
            if (kept)
            begin
                delay_two[ch] = w1;
                delay_one[ch] = w;
            end
            res.sample = y[SAMPLE_W-1:0];
            res.chan   = ch;
            expected_q.push_back(res);
        endfunction

        function void check_filtered(logic signed [SAMPLE_W-1:0] sample, logic [CHAN_W-1:0] ch);
            filtered_beat_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: sample %0d chan %0d", sample, ch);
                return;
            end
            want = expected_q.pop_front();
            if (want.sample !== sample || want.chan !== ch)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected sample %0d chan %0d, got sample %0d chan %0d",
                             want.sample, want.chan, sample, ch);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in  = '0;
    logic [CHAN_W-1:0]          chan_index = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHAN_W-1:0]          chan_out;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic signed [COEF_W-1:0]   cfg_data   = '0;

    bit bursts_on     = 1'b1;
    bit long_hold_req = 1'b0;
    int idle_cycles   = 0;

    biquad_scoreboard sb = new;

    biquad_df2_multichannel_filter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .chan_index (chan_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .chan_out   (chan_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_coef(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_sample(sample_in, chan_index);
            if (out_valid && out_ready)
                sb.check_filtered(sample_out, chan_out);
        end
    end

    // watchdog: cycles with no beat on any channel
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("biquad_df2_multichannel_filter_tb: FAIL");
        $finish;
    end

    // result sink
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] x,
                                input logic [CHAN_W-1:0] ch);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample_in  <= x;
        chan_index <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // one write to an unused index first, which must be dropped
    task automatic load_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
        cfg_beat(CFG_IDX_W'($urandom_range(int'(REG_A2) + 1, (1 << CFG_IDX_W) - 1)),
                 COEF_W'($urandom));
        cfg_beat(REG_B0, b0);
        cfg_beat(REG_B1, b1);
        cfg_beat(REG_B2, b2);
        cfg_beat(REG_A1, a1);
        cfg_beat(REG_A2, a2);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] x;
        logic signed [COEF_W-1:0]   b0, b1, b2, a1, a2;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: pass-through
        offer_sample(S_MAX, 3'd0);
        offer_sample(S_MIN, 3'd1);
        offer_sample('0, 3'd2);
        offer_sample(-24'sd1, 3'd3);
        offer_sample(24'sd1, 3'd4);
        offer_sample(24'sh555555, 3'd5);
        offer_sample(24'shAAAAAA, 3'd6);
        offer_sample(S_MAX, 3'd7);
        drain_results();

        // extreme coefficients: saturation of w and y
        load_coefs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        offer_sample(S_MAX, 3'd0);
        offer_sample(S_MIN, 3'd0);
        offer_sample(S_MAX, 3'd1);
        drain_results();
        load_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        offer_sample(S_MAX, 3'd2);
        offer_sample(S_MIN, 3'd2);
        offer_sample(24'sd1, 3'd3);
        drain_results();
        load_coefs(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
        offer_sample(S_MIN, 3'd4);
        offer_sample(S_MAX, 3'd4);
        offer_sample(S_MIN, 3'd4);
        drain_results();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    b0 = 24'sd52429;   b1 = 24'sd104858; b2 = 24'sd52429;
                    a1 = -24'sd235930; a2 = 24'sd52429;
                end
                2:
                begin
                    b0 = COEF_W'($urandom); b1 = COEF_W'($urandom); b2 = COEF_W'($urandom);
                    a1 = COEF_W'($urandom); a2 = COEF_W'($urandom);
                end
                4:
                begin
                    b0 = 24'sd13107;   b1 = '0;           b2 = -24'sd13107;
                    a1 = -24'sd471859; a2 = 24'sd249037;
                end
                default:
                begin
                    b0 = COEF_W'(int'($urandom_range(0, 524288)) - 262144);
                    b1 = COEF_W'(int'($urandom_range(0, 524288)) - 262144);
                    b2 = COEF_W'(int'($urandom_range(0, 524288)) - 262144);
                    a1 = COEF_W'(int'($urandom_range(0, 786432)) - 393216);
                    a2 = COEF_W'(int'($urandom_range(0, 393216)) - 196608);
                end
            endcase
            load_coefs(b0, b1, b2, a1, a2);
            bursts_on = (p != RAND_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 100)
                    long_hold_req = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    x = SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
                else
                    x = SAMPLE_W'($urandom);
                offer_sample(x, CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1)));
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("biquad_df2_multichannel_filter_tb: PASS");
        else
            $display("biquad_df2_multichannel_filter_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/bq_pkg.sv
src/bq_ram.sv
src/bq_ctrl.sv
src/bq_dp.sv
src/biquad_df2_multichannel_filter.sv
tb/biquad_df2_multichannel_filter_tb.sv
